/* design/sdw_pkg.sv */
package sdw_pkg;

   localparam int MAX_POINTS = 8;
   localparam int MAX_DERIV  = 2;
   localparam int NUM_W      = MAX_POINTS * (MAX_DERIV + 1);
   localparam int WA_W       = $clog2(NUM_W);
   localparam int PT_W       = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int K_W        = (MAX_DERIV > 0) ? $clog2(MAX_DERIV + 1) : 1;
   localparam int DIV_STEPS  = 96;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic signed [47:0] W_MAX     = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] W_MIN     = 48'sh8000_0000_0000;
   localparam logic signed [47:0] ONE_Q32   = 48'sh0001_0000_0000;
   localparam logic signed [48:0] ONE_Q28_A = 49'sh0_0000_1000_0000;
   localparam logic signed [33:0] ONE_Q28_D = 34'sh0_1000_0000;
   localparam logic signed [33:0] ONE_Q32_D = 34'sh1_0000_0000;

   typedef struct packed {
      logic signed [31:0] grid_coord;
      logic signed [31:0] eval_point;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [47:0] weight;
      logic [2:0]         point_index;
      logic [1:0]         deriv_index;
      logic               overflow;
      logic               final_res;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_LD_XI,
      OP_LD_XIM1,
      OP_LD_XJ,
      OP_SET_C4,
      OP_RD_WA,
      OP_RD_WB,
      OP_MD_R_STEP,
      OP_MD_R_FIN,
      OP_MD_C5W,
      OP_MD_C5W0,
      OP_MD_RT,
      OP_MD_C4W,
      OP_MD_TC3,
      OP_MD_C4W0
   } dp_op_type;

   typedef struct packed {
      dp_op_type       op;
      logic            start;
      logic [PT_W-1:0] caddr;
      logic [WA_W-1:0] waddr;
      logic [K_W-1:0]  kval;
      logic            coord_we;
      logic            tgt_we;
   } dp_cmd_type;

   typedef struct packed {
      logic md_done;
      logic ovf;
   } dp_sts_type;

   typedef struct packed {
      logic [2:0] point_index;
      logic [1:0] deriv_index;
      logic       final_res;
   } rsp_info_type;

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_FIN
   } md_state_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_INIT,
      S_LD0,
      S_SC0,
      S_I_XI,
      S_I_XIM1,
      S_I_C4,
      S_R_CHK,
      S_R_XJ,
      S_R_MD,
      S_R_FIN,
      S_K_CHK,
      S_K_RDA,
      S_K_RDB,
      S_K_MD1,
      S_K_MD2,
      S_K0_RDA,
      S_K0_MD1,
      S_K0_MD2,
      S_J_CHK,
      S_J_XJ,
      S_JK_CHK,
      S_JK_RDA,
      S_JK_RDB,
      S_JK_MD1,
      S_JK_MD2,
      S_JK0_RDA,
      S_JK0_MD,
      S_O_RD,
      S_O_SHOW
   } ctrl_state_type;

   // weight table address, point-major
   function automatic logic [WA_W-1:0] widx(logic [PT_W-1:0] j, logic [K_W-1:0] k);
      return WA_W'(j * (MAX_DERIV + 1) + k);
   endfunction

endpackage

/* design/stencil_derivative_weights_top.sv */
// Finite-difference / interpolation weight engine. Send up to MAX_POINTS
// stencil coordinates (signed Q4.28), one per transfer; eval_point is taken
// from the first transfer of a run, and the transfer with last set closes the
// stencil and starts the computation. Extra coordinates past MAX_POINTS are
// dropped. The block then returns one Q16.32 weight per point and derivative
// order (orders 0..deriv_order, capped at MAX_DERIV), point-major, with
// final_res on the last one. overflow is common to all results of a run and
// flags any saturation or a zero divisor from repeated coordinates.
// Flow: loading takes one coordinate per cycle. The multiplies and divides
// of the recurrence run on one shared multiply-divide unit (shift-add
// multiply from 48x16 partial products, 96-step restoring divide; a zero
// divisor skips both). For n points and order m, point i (1..n-1) needs
// i + 2*(min(i,m)+1) + i*(2*min(i,m)+1) multiply-divides, plus coordinate
// loads and table reads around them; the drain then reads each result from
// the table and shows it until it is taken. req_stall stays high from
// the last transfer until the final result has been taken. deriv_order
// should only be written while the block is idle.
module stencil_derivative_weights_top
   import sdw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   dp_cmd_type         cmd;
   dp_sts_type         sts;
   rsp_info_type       info;
   logic signed [47:0] weight;

   // sequencer: load counting, loop indices, result ordering
   sdw_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last    (req_data.last),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_info    (info),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts)
   );

   // coordinate store, weight table, operand regs and multiply-divide unit
   sdw_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .sts      (sts),
      .weight   (weight)
   );

   // payload is held stable while a result waits
   assign rsp_data.weight      = weight;
   assign rsp_data.point_index = info.point_index;
   assign rsp_data.deriv_index = info.deriv_index;
   assign rsp_data.overflow    = sts.ovf;
   assign rsp_data.final_res   = info.final_res;

endmodule

/* design/sdw_muldiv.sv */
module sdw_muldiv
   import sdw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [48:0] opa,
   input  logic signed [48:0] opb,
   input  logic signed [33:0] opd,
   output logic               done,
   output logic               ovf,
   output logic signed [47:0] quo
);

   md_state_type      state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [47:0]       ua_ff, ua_in, ub_ff, ub_in;
   logic [33:0]       ud_ff, ud_in;
   logic [95:0]       prod_ff, prod_in;
   logic [34:0]       rem_ff, rem_in;
   logic [47:0]       quo_ff, quo_in;
   logic              hi_ff, hi_in;
   logic [47:0]       res_ff, res_in;
   logic              ovf_ff, ovf_in;
   logic              done_ff, done_in;

   logic signed [48:0] na, nb;
   logic signed [33:0] nd;
   logic [47:0]        ua_s, ub_s;
   logic [33:0]        ud_s;
   logic [63:0]        part;
   logic [34:0]        rem2;
   logic [47:0]        lim, negq;
   logic               big;

   always_comb begin
      na   = -opa;
      nb   = -opb;
      nd   = -opd;
      ua_s = opa[48] ? na[47:0] : opa[47:0];
      ub_s = opb[48] ? nb[47:0] : opb[47:0];
      ud_s = opd[33] ? nd : opd;
      part = ua_ff * ub_ff[47:32];
      rem2 = {rem_ff[33:0], prod_ff[95]};
      lim  = neg_ff ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      negq = -quo_ff;
      big  = hi_ff || (quo_ff > lim);

      state_in = state_ff;
      step_in  = step_ff;
      neg_in   = neg_ff;
      ua_in    = ua_ff;
      ub_in    = ub_ff;
      ud_in    = ud_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      hi_in    = hi_ff;
      res_in   = res_ff;
      ovf_in   = ovf_ff;
      done_in  = 1'b0;

      unique case (state_ff)
         MD_IDLE: begin
            if (start) begin
               neg_in  = (opa[48] ^ opb[48]) ^ opd[33];
               ua_in   = ua_s;
               ub_in   = ub_s;
               ud_in   = ud_s;
               prod_in = '0;
               rem_in  = '0;
               quo_in  = '0;
               hi_in   = 1'b0;
               step_in = '0;
               if (ud_s == '0) begin
                  // zero divisor: flagged, zero or saturated by sign
                  ovf_in  = 1'b1;
                  done_in = 1'b1;
                  if (ua_s == '0 || ub_s == '0) begin
                     res_in = '0;
                  end else begin
                     res_in = ((opa[48] ^ opb[48]) ^ opd[33]) ? W_MIN : W_MAX;
                  end
               end else begin
                  state_in = MD_MUL;
               end
            end
         end
         MD_MUL: begin
            prod_in = {prod_ff[79:0], 16'h0000} + 96'(part);
            ub_in   = {ub_ff[31:0], 16'h0000};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(2)) begin
               step_in  = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            prod_in = {prod_ff[94:0], 1'b0};
            hi_in   = hi_ff | quo_ff[47];
            if (rem2 >= {1'b0, ud_ff}) begin
               rem_in = rem2 - {1'b0, ud_ff};
               quo_in = {quo_ff[46:0], 1'b1};
            end else begin
               rem_in = rem2;
               quo_in = {quo_ff[46:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = MD_FIN;
            end
         end
         MD_FIN: begin
            ovf_in   = big;
            done_in  = 1'b1;
            state_in = MD_IDLE;
            if (big) begin
               res_in = neg_ff ? W_MIN : W_MAX;
            end else begin
               res_in = neg_ff ? negq : quo_ff;
            end
         end
         default: begin
            state_in = MD_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      neg_ff  <= neg_in;
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      ud_ff   <= ud_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      hi_ff   <= hi_in;
      res_ff  <= res_in;
      ovf_ff  <= ovf_in;
   end

   assign done = done_ff;
   assign ovf  = ovf_ff;
   assign quo  = res_ff;

endmodule

/* design/sdw_datapath.sv */
module sdw_datapath
   import sdw_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   input  req_type            req_data,
   output dp_sts_type         sts,
   output logic signed [47:0] weight
);

   logic signed [31:0] cmem [MAX_POINTS];
   logic signed [47:0] wmem [NUM_W];
   logic [NUM_W-1:0]   wvalid_ff;
   logic               ovf_ff;

   logic signed [31:0] tgt_ff, xi_ff, xim1_ff, xj_ff;
   logic signed [32:0] c4_ff, c5_ff;
   logic signed [47:0] r_ff, wa_ff, wb_ff;
   logic signed [48:0] t_ff;

   logic signed [48:0] md_a, md_b;
   logic signed [33:0] md_d;
   logic               md_done, md_ovf;
   logic signed [47:0] md_q;

   logic signed [32:0] dxij, dxim1j, dxiim1;
   logic signed [50:0] kw, diff5, diff4, dsel;
   logic signed [47:0] tsat;
   logic               sat_hit;

   logic               w_we;
   logic [WA_W-1:0]    w_addr;
   logic signed [47:0] w_data;

   always_comb begin
      dxij   = 33'(xi_ff) - 33'(xj_ff);
      dxim1j = 33'(xim1_ff) - 33'(xj_ff);
      dxiim1 = 33'(xi_ff) - 33'(xim1_ff);
      kw     = 51'(wb_ff) * $signed({1'b0, cmd.kval});
      diff5  = kw - 51'(md_q);
      diff4  = 51'(md_q) - kw;
      dsel   = (cmd.op == OP_MD_C4W) ? diff4 : diff5;
      sat_hit = 1'b0;
      if (dsel > 51'(W_MAX)) begin
         tsat    = W_MAX;
         sat_hit = 1'b1;
      end else if (dsel < 51'(W_MIN)) begin
         tsat    = W_MIN;
         sat_hit = 1'b1;
      end else begin
         tsat = 48'(dsel);
      end

      md_a = '0;
      md_b = '0;
      md_d = '0;
      case (cmd.op) inside
         OP_MD_R_STEP: begin
            md_a = 49'(r_ff);
            md_b = 49'(dxim1j);
            md_d = 34'(dxij);
         end
         OP_MD_R_FIN: begin
            md_a = 49'(r_ff);
            md_b = ONE_Q28_A;
            md_d = 34'(dxiim1);
         end
         OP_MD_C5W, OP_MD_C5W0: begin
            md_a = 49'(c5_ff);
            md_b = 49'(wa_ff);
            md_d = ONE_Q28_D;
         end
         OP_MD_RT: begin
            md_a = 49'(r_ff);
            md_b = t_ff;
            md_d = ONE_Q32_D;
         end
         OP_MD_C4W: begin
            md_a = 49'(c4_ff);
            md_b = 49'(wa_ff);
            md_d = ONE_Q28_D;
         end
         OP_MD_TC3: begin
            md_a = t_ff;
            md_b = ONE_Q28_A;
            md_d = 34'(dxij);
         end
         OP_MD_C4W0: begin
            md_a = 49'(c4_ff);
            md_b = 49'(wa_ff);
            md_d = 34'(dxij);
         end
         default: begin
            md_a = '0;
         end
      endcase

      w_we   = 1'b0;
      w_addr = cmd.waddr;
      w_data = md_q;
      if (cmd.op == OP_INIT) begin
         w_we   = 1'b1;
         w_addr = '0;
         w_data = ONE_Q32;
      end else if (md_done && (cmd.op == OP_MD_RT || cmd.op == OP_MD_TC3 ||
                               cmd.op == OP_MD_C4W0)) begin
         w_we = 1'b1;
      end
   end

   sdw_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (cmd.start),
      .opa   (md_a),
      .opb   (md_b),
      .opd   (md_d),
      .done  (md_done),
      .ovf   (md_ovf),
      .quo   (md_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.coord_we) begin
         cmem[cmd.caddr] <= req_data.grid_coord;
      end
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         wmem[w_addr] <= w_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_ff <= '0;
      end else if (cmd.tgt_we) begin
         tgt_ff <= req_data.eval_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         if (cmd.op == OP_INIT) begin
            wvalid_ff <= NUM_W'(1);
            ovf_ff    <= 1'b0;
         end else begin
            if (w_we) begin
               wvalid_ff[w_addr] <= 1'b1;
            end
            if (md_done) begin
               ovf_ff <= ovf_ff | md_ovf |
                         (sat_hit && (cmd.op == OP_MD_C5W || cmd.op == OP_MD_C4W));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LD_XI:   xi_ff   <= cmem[cmd.caddr];
         OP_LD_XIM1: xim1_ff <= cmem[cmd.caddr];
         OP_LD_XJ:   xj_ff   <= cmem[cmd.caddr];
         OP_SET_C4: begin
            c5_ff <= c4_ff;
            c4_ff <= 33'(xi_ff) - 33'(tgt_ff);
            r_ff  <= ONE_Q32;
         end
         OP_RD_WA: wa_ff <= wvalid_ff[cmd.waddr] ? wmem[cmd.waddr] : '0;
         OP_RD_WB: wb_ff <= wvalid_ff[cmd.waddr] ? wmem[cmd.waddr] : '0;
         default: begin
         end
      endcase
      if (md_done) begin
         case (cmd.op) inside
            OP_MD_R_STEP, OP_MD_R_FIN: r_ff <= md_q;
            OP_MD_C5W, OP_MD_C4W:      t_ff <= 49'(tsat);
            OP_MD_C5W0:                t_ff <= -49'(md_q);
            default: begin
            end
         endcase
      end
   end

   assign sts.md_done = md_done;
   assign sts.ovf     = ovf_ff;
   assign weight      = wa_ff;

endmodule

/* design/sdw_ctrl.sv */
module sdw_ctrl
   import sdw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_info_type rsp_info,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data,
   output dp_cmd_type   cmd,
   input  dp_sts_type   sts
);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, n_ff, n_in, i_ff, i_in, j_ff, j_in;
   logic [K_W-1:0]   k_ff, k_in, m_ff, m_in, mn_ff, mn_in;
   logic [1:0]       order_ff;
   logic             issued_ff, issued_in;

   logic [CNT_W-1:0] cnt_next, i_next;
   logic [PT_W-1:0]  pi, pim1, pj;
   logic             is_final;

   always_comb begin
      pi       = PT_W'(i_ff);
      pim1     = PT_W'(i_ff - CNT_W'(1));
      pj       = PT_W'(j_ff);
      i_next   = i_ff + CNT_W'(1);
      cnt_next = (cnt_ff < CNT_W'(MAX_POINTS)) ? cnt_ff + CNT_W'(1) : cnt_ff;
      is_final = (j_ff == n_ff - CNT_W'(1)) && (k_ff == m_ff);

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      m_in      = m_ff;
      mn_in     = mn_ff;
      issued_in = issued_ff;
      cmd       = '0;
      cmd.op    = OP_NONE;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.caddr   = PT_W'(cnt_ff);
            if (req_valid) begin
               cmd.coord_we = (cnt_ff < CNT_W'(MAX_POINTS));
               cmd.tgt_we   = (cnt_ff == '0);
               cnt_in       = cnt_next;
               if (req_last) begin
                  n_in     = cnt_next;
                  cnt_in   = '0;
                  m_in     = (order_ff < MAX_DERIV) ? K_W'(order_ff) : K_W'(MAX_DERIV);
                  state_in = S_INIT;
               end
            end
         end
         S_INIT: begin
            cmd.op   = OP_INIT;
            state_in = S_LD0;
         end
         S_LD0: begin
            cmd.op    = OP_LD_XI;
            cmd.caddr = '0;
            state_in  = S_SC0;
         end
         S_SC0: begin
            cmd.op = OP_SET_C4;
            i_in   = CNT_W'(1);
            j_in   = '0;
            k_in   = '0;
            state_in = (n_ff == CNT_W'(1)) ? S_O_RD : S_I_XI;
         end
         S_I_XI: begin
            cmd.op    = OP_LD_XI;
            cmd.caddr = pi;
            state_in  = S_I_XIM1;
         end
         S_I_XIM1: begin
            cmd.op    = OP_LD_XIM1;
            cmd.caddr = pim1;
            state_in  = S_I_C4;
         end
         S_I_C4: begin
            cmd.op   = OP_SET_C4;
            j_in     = '0;
            mn_in    = (i_ff < CNT_W'(m_ff)) ? K_W'(i_ff) : m_ff;
            state_in = S_R_CHK;
         end
         S_R_CHK: begin
            state_in = (i_ff > j_ff + CNT_W'(1)) ? S_R_XJ : S_R_FIN;
         end
         S_R_XJ: begin
            cmd.op    = OP_LD_XJ;
            cmd.caddr = pj;
            state_in  = S_R_MD;
         end
         S_R_MD: begin
            cmd.op    = OP_MD_R_STEP;
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               j_in      = j_ff + CNT_W'(1);
               state_in  = S_R_CHK;
            end
         end
         S_R_FIN: begin
            cmd.op    = OP_MD_R_FIN;
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               k_in      = mn_ff;
               state_in  = S_K_CHK;
            end
         end
         S_K_CHK: begin
            state_in = (k_ff != '0) ? S_K_RDA : S_K0_RDA;
         end
         S_K_RDA: begin
            cmd.op    = OP_RD_WA;
            cmd.waddr = widx(pim1, k_ff);
            state_in  = S_K_RDB;
         end
         S_K_RDB: begin
            cmd.op    = OP_RD_WB;
            cmd.waddr = widx(pim1, k_ff - K_W'(1));
            state_in  = S_K_MD1;
         end
         S_K_MD1: begin
            cmd.op    = OP_MD_C5W;
            cmd.kval  = k_ff;
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               state_in  = S_K_MD2;
            end
         end
         S_K_MD2: begin
            cmd.op    = OP_MD_RT;
            cmd.waddr = widx(pi, k_ff);
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               k_in      = k_ff - K_W'(1);
               state_in  = S_K_CHK;
            end
         end
         S_K0_RDA: begin
            cmd.op    = OP_RD_WA;
            cmd.waddr = widx(pim1, '0);
            state_in  = S_K0_MD1;
         end
         S_K0_MD1: begin
            cmd.op    = OP_MD_C5W0;
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               state_in  = S_K0_MD2;
            end
         end
         S_K0_MD2: begin
            cmd.op    = OP_MD_RT;
            cmd.waddr = widx(pi, '0);
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               j_in      = '0;
               state_in  = S_J_CHK;
            end
         end
         S_J_CHK: begin
            if (j_ff < i_ff) begin
               state_in = S_J_XJ;
            end else begin
               i_in = i_next;
               j_in = '0;
               k_in = '0;
               state_in = (i_next < n_ff) ? S_I_XI : S_O_RD;
            end
         end
         S_J_XJ: begin
            cmd.op    = OP_LD_XJ;
            cmd.caddr = pj;
            k_in      = mn_ff;
            state_in  = S_JK_CHK;
         end
         S_JK_CHK: begin
            state_in = (k_ff != '0) ? S_JK_RDA : S_JK0_RDA;
         end
         S_JK_RDA: begin
            cmd.op    = OP_RD_WA;
            cmd.waddr = widx(pj, k_ff);
            state_in  = S_JK_RDB;
         end
         S_JK_RDB: begin
            cmd.op    = OP_RD_WB;
            cmd.waddr = widx(pj, k_ff - K_W'(1));
            state_in  = S_JK_MD1;
         end
         S_JK_MD1: begin
            cmd.op    = OP_MD_C4W;
            cmd.kval  = k_ff;
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               state_in  = S_JK_MD2;
            end
         end
         S_JK_MD2: begin
            cmd.op    = OP_MD_TC3;
            cmd.waddr = widx(pj, k_ff);
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               k_in      = k_ff - K_W'(1);
               state_in  = S_JK_CHK;
            end
         end
         S_JK0_RDA: begin
            cmd.op    = OP_RD_WA;
            cmd.waddr = widx(pj, '0);
            state_in  = S_JK0_MD;
         end
         S_JK0_MD: begin
            cmd.op    = OP_MD_C4W0;
            cmd.waddr = widx(pj, '0);
            cmd.start = !issued_ff;
            issued_in = 1'b1;
            if (sts.md_done) begin
               issued_in = 1'b0;
               j_in      = j_ff + CNT_W'(1);
               state_in  = S_J_CHK;
            end
         end
         S_O_RD: begin
            cmd.op    = OP_RD_WA;
            cmd.waddr = widx(pj, k_ff);
            state_in  = S_O_SHOW;
         end
         S_O_SHOW: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (is_final) begin
                  state_in = S_IDLE;
               end else if (k_ff == m_ff) begin
                  k_in     = '0;
                  j_in     = j_ff + CNT_W'(1);
                  state_in = S_O_RD;
               end else begin
                  k_in     = k_ff + K_W'(1);
                  state_in = S_O_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         order_ff  <= 2'd1;
         issued_ff <= 1'b0;
         n_ff      <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
         m_ff      <= '0;
         mn_ff     <= '0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         issued_ff <= issued_in;
         n_ff      <= n_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
         m_ff      <= m_in;
         mn_ff     <= mn_in;
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
      end
   end

   assign rsp_info.point_index = 3'(j_ff);
   assign rsp_info.deriv_index = 2'(k_ff);
   assign rsp_info.final_res   = is_final;

endmodule
